[rtl/core/tbm_pkg.sv]
package tbm_pkg;

   // Pool geometry. Transmit ids are 0 .. TX_BUFS-1, receive ids run up to TOTAL_BUFS-1.
   localparam int TX_BUFS    = 8;
   localparam int TOTAL_BUFS = 32;
   localparam int IDX_W      = $clog2(TX_BUFS);
   localparam int CNT_W      = $clog2(TX_BUFS + 1);

   // Frame sizes above these need three or two buffers.
   localparam logic [15:0] THRESH_THREE = 16'd8312;
   localparam logic [15:0] THRESH_TWO   = 16'd4186;

   localparam logic [3:0] RETRY_MAX = 4'hF;

   typedef enum logic [2:0] {
      REQ_GET      = 3'd0,
      REQ_RESIZE   = 3'd1,
      REQ_RELEASE  = 3'd2,
      REQ_START    = 3'd3,
      REQ_COMPLETE = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      CSR_MIN_SIZE    = 2'd0,
      CSR_MAX_SIZE    = 2'd1,
      CSR_RETRY_LIMIT = 2'd2
   } csr_index_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_WAIT    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   localparam logic [1:0] ACT_NONE   = 2'd0;
   localparam logic [1:0] ACT_RESEND = 2'd1;
   localparam logic [1:0] ACT_OK     = 2'd2;
   localparam logic [1:0] ACT_FAIL   = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] size;
      logic [7:0]  buf_id;
      logic        auto_release;
      logic        err_any;
      logic        err_late_collision;
      logic        err_loss_carrier;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  granted_id;
      logic [15:0] frame_size;
      logic [15:0] sequence_res;
      logic [1:0]  tx_action;
      logic        wake_waiter;
      logic        give_to_receiver;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] min_size;
      logic [15:0] max_size;
      logic [3:0]  retry_limit;
   } cfg_type;

   typedef struct packed {
      logic [TX_BUFS-1:0] free_mask;
      logic [CNT_W-1:0]   free_count;
      logic               waiter;
   } pool_state_type;

endpackage

[rtl/core/tx_buffer_manager.sv]
// Transmit buffer pool manager.
// A request word is held in the request register, its result word in the result register.
// Throughput: one request word per cycle while results are taken; the pool decision is one
// pass of logic between the request register and the result register.
// Reset (synchronous, active high): all transmit buffers free, no waiter, sequence zero,
// retry counts zero, sizes 60 to 1514 bytes, retry limit three.
module tx_buffer_manager (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [15:0] req_size,
   input  logic [7:0]  req_buf_id,
   input  logic        req_auto_release,
   input  logic        req_err_any,
   input  logic        req_err_late_collision,
   input  logic        req_err_loss_carrier,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_granted_id,
   output logic [15:0] rsp_frame_size,
   output logic [15:0] rsp_sequence_res,
   output logic [1:0]  rsp_tx_action,
   output logic        rsp_wake_waiter,
   output logic        rsp_give_to_receiver,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import tbm_pkg::*;

   // Request register: holds one word until the pool logic has evaluated it.
   logic           req_valid_ff;
   req_item_type   req_item_ff;
   req_item_type   req_item_in;

   // Result register: holds the answer until the consumer takes it.
   logic           rsp_valid_ff;
   rsp_item_type   rsp_item_ff;

   cfg_type        cfg_ff;
   rsp_item_type   result;
   pool_state_type pool_state;
   logic           advance;

   // The pool state is updated exactly when a request moves into the result register,
   // so back-to-back requests always see the effect of the one before.
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign req_item_in.kind               = req_type;
   assign req_item_in.size               = req_size;
   assign req_item_in.buf_id             = req_buf_id;
   assign req_item_in.auto_release       = req_auto_release;
   assign req_item_in.err_any            = req_err_any;
   assign req_item_in.err_late_collision = req_err_late_collision;
   assign req_item_in.err_loss_carrier   = req_err_loss_carrier;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         req_item_ff <= req_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   // Configuration words land directly; an index beyond the register list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_size    <= 16'd60;
         cfg_ff.max_size    <= 16'd1514;
         cfg_ff.retry_limit <= 4'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_SIZE:    cfg_ff.min_size    <= csr_wdata;
            CSR_MAX_SIZE:    cfg_ff.max_size    <= csr_wdata;
            CSR_RETRY_LIMIT: cfg_ff.retry_limit <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   tbm_pool u_pool (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .fire       (advance),
      .item       (req_item_ff),
      .result     (result),
      .pool_state (pool_state)
   );

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_item_ff.status;
   assign rsp_granted_id       = rsp_item_ff.granted_id;
   assign rsp_frame_size       = rsp_item_ff.frame_size;
   assign rsp_sequence_res     = rsp_item_ff.sequence_res;
   assign rsp_tx_action        = rsp_item_ff.tx_action;
   assign rsp_wake_waiter      = rsp_item_ff.wake_waiter;
   assign rsp_give_to_receiver = rsp_item_ff.give_to_receiver;

   // The free count always equals the number of free buffers in the mask.
   a_count_matches_mask: assert property (@(posedge clock) disable iff (reset)
      pool_state.free_count == CNT_W'($countones(pool_state.free_mask)))
      else $error("free count out of step with free mask");

   // A pending request is never dropped while the result register is stalled.
   a_request_held: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && rsp_valid_ff && !rsp_ready |=> req_valid_ff)
      else $error("pending request lost during output stall");

   // A wait answer leaves a waiter marked.
   a_wait_marks_waiter: assert property (@(posedge clock) disable iff (reset)
      advance && (result.status == ST_WAIT) |=> pool_state.waiter)
      else $error("wait answer without waiter mark");

   // A new result only appears after a request was evaluated.
   a_result_from_request: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without a request");

endmodule

[rtl/core/tbm_pool.sv]
module tbm_pool (
   input  logic                    clock,
   input  logic                    reset,
   input  tbm_pkg::cfg_type        cfg,
   input  logic                    fire,
   input  tbm_pkg::req_item_type   item,
   output tbm_pkg::rsp_item_type   result,
   output tbm_pkg::pool_state_type pool_state
);
   import tbm_pkg::*;

   logic [TX_BUFS-1:0] free_mask_ff, free_mask_in;
   logic [CNT_W-1:0]   free_count_ff, free_count_in;
   logic               waiter_ff, waiter_in;
   logic [15:0]        seq_ff, seq_in;
   logic [15:0]        sizes_ff [TX_BUFS];
   logic [3:0]         retry_ff [TX_BUFS];

   logic [IDX_W-1:0]   id_idx;
   logic               id_tx_ok;
   logic               id_total_ok;
   logic [1:0]         need;
   logic [IDX_W-1:0]   low_idx;
   logic [15:0]        clamped;
   logic [3:0]         retry_cnt;
   logic [TX_BUFS-1:0] rel_bit;

   logic               size_we;
   logic [IDX_W-1:0]   size_idx;
   logic               retry_we;
   logic               retry_clr;
   logic               do_release;

   assign id_idx      = item.buf_id[IDX_W-1:0];
   assign id_tx_ok    = item.buf_id < 8'(TX_BUFS);
   assign id_total_ok = {1'b0, item.buf_id} < 9'(TOTAL_BUFS);
   assign retry_cnt   = retry_ff[id_idx];
   assign rel_bit     = TX_BUFS'(1) << id_idx;

   assign need = (item.size > THRESH_THREE) ? 2'd3 :
                 (item.size > THRESH_TWO)   ? 2'd2 : 2'd1;

   // Lowest set bit of the free mask.
   always_comb begin
      low_idx = '0;
      for (int k = TX_BUFS - 1; k >= 0; k--) begin
         if (free_mask_ff[k]) begin
            low_idx = IDX_W'(k);
         end
      end
   end

   // Minimum wins over maximum; in range, odd sizes round up unless already all ones.
   always_comb begin
      if (item.size < cfg.min_size) begin
         clamped = cfg.min_size;
      end else if (item.size > cfg.max_size) begin
         clamped = cfg.max_size;
      end else if (item.size[0] && (item.size != 16'hFFFF)) begin
         clamped = item.size + 16'd1;
      end else begin
         clamped = item.size;
      end
   end

   always_comb begin
      result        = '0;
      free_mask_in  = free_mask_ff;
      free_count_in = free_count_ff;
      waiter_in     = waiter_ff;
      seq_in        = seq_ff;
      size_we       = 1'b0;
      size_idx      = id_idx;
      retry_we      = 1'b0;
      retry_clr     = 1'b0;
      do_release    = 1'b0;

      unique case (item.kind)
         REQ_GET: begin
            if ((free_mask_ff == '0) || (CNT_W'(need) > free_count_ff)) begin
               result.status = ST_WAIT;
               waiter_in     = 1'b1;
            end else begin
               free_count_in       = free_count_ff - CNT_W'(1);
               free_mask_in        = free_mask_ff & ~(TX_BUFS'(1) << low_idx);
               size_we             = 1'b1;
               size_idx            = low_idx;
               result.granted_id   = 8'(low_idx);
               result.frame_size   = clamped;
               result.sequence_res = seq_ff;
               seq_in              = seq_ff + 16'd1;
            end
         end
         REQ_RESIZE: begin
            if (!id_tx_ok) begin
               result.status = ST_INVALID;
            end else begin
               size_we           = 1'b1;
               result.frame_size = clamped;
            end
         end
         REQ_RELEASE: begin
            if (!id_total_ok) begin
               result.status = ST_INVALID;
            end else if (id_tx_ok) begin
               do_release = 1'b1;
            end else begin
               result.give_to_receiver = 1'b1;
            end
         end
         REQ_START: begin
            if (!id_tx_ok) begin
               result.status = ST_INVALID;
            end else begin
               retry_clr = 1'b1;
            end
         end
         REQ_COMPLETE: begin
            if (!id_tx_ok) begin
               result.status = ST_INVALID;
            end else begin
               result.frame_size = sizes_ff[id_idx];
               if (item.err_any && (item.err_late_collision || item.err_loss_carrier)) begin
                  retry_we = (retry_cnt != RETRY_MAX);
               end
               if (item.err_any && (item.err_late_collision || item.err_loss_carrier) &&
                   (retry_cnt < cfg.retry_limit)) begin
                  result.tx_action = ACT_RESEND;
               end else begin
                  result.tx_action = item.err_any ? ACT_FAIL : ACT_OK;
                  do_release       = item.auto_release;
               end
            end
         end
         default: begin
         end
      endcase

      if (do_release) begin
         result.wake_waiter = waiter_ff;
         waiter_in          = 1'b0;
         if ((free_mask_ff & rel_bit) == '0) begin
            free_mask_in = free_mask_ff | rel_bit;
            if (free_count_ff < CNT_W'(TX_BUFS)) begin
               free_count_in = free_count_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_mask_ff  <= '1;
         free_count_ff <= CNT_W'(TX_BUFS);
         waiter_ff     <= 1'b0;
         seq_ff        <= '0;
         for (int i = 0; i < TX_BUFS; i++) begin
            retry_ff[i] <= '0;
         end
      end else if (fire) begin
         free_mask_ff  <= free_mask_in;
         free_count_ff <= free_count_in;
         waiter_ff     <= waiter_in;
         seq_ff        <= seq_in;
         if (retry_clr) begin
            retry_ff[id_idx] <= '0;
         end else if (retry_we) begin
            retry_ff[id_idx] <= retry_cnt + 4'd1;
         end
      end
   end

   // Frame sizes have no reset value.
   always_ff @(posedge clock) begin
      if (fire && size_we) begin
         sizes_ff[size_idx] <= clamped;
      end
   end

   assign pool_state.free_mask  = free_mask_ff;
   assign pool_state.free_count = free_count_ff;
   assign pool_state.waiter     = waiter_ff;

endmodule
